FILE: src/ptrs_pkg.sv
// Shared types and constants for the periodic task release scheduler.
// No dependencies; imported by ptrs_table, periodic_task_release_scheduler and the testbench files.
package ptrs_pkg;

   localparam int TASK_COUNT_DEF = 8;
   localparam int MAX_RELEASES   = 8;
   localparam int REL_CNT_W      = 4;
   localparam int TICK_W         = 32;
   localparam int KIND_W         = 2;
   localparam int TASK_ID_W      = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK    = 2'd0,
      KIND_LOAD    = 2'd1,
      KIND_SUSPEND = 2'd2
   } req_kind_type;

   typedef struct packed {
      logic [TICK_W-1:0] remaining_ticks;
      logic [TICK_W-1:0] period_ticks;
      logic              has_handler;
      logic              running;
   } task_entry_type;

endpackage

FILE: src/ptrs_table.sv
// Task table: one synchronous memory of task entries with a registered read port.
// Per-entry valid bits make unwritten entries read as all zero. Uses ptrs_pkg.
module ptrs_table
   import ptrs_pkg::*;
#(
   parameter int TASK_COUNT = TASK_COUNT_DEF,
   parameter int AW         = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           rd_en,
   input  logic [AW-1:0]  rd_addr,
   output task_entry_type rd_entry,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  task_entry_type wr_entry
);

   task_entry_type            mem [TASK_COUNT];
   logic [TASK_COUNT-1:0]     ent_vld_ff;
   task_entry_type            rd_data_ff;
   logic                      rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            ent_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= ent_vld_ff[rd_addr];
         end
      end
   end

   assign rd_entry = rd_vld_ff ? rd_data_ff : '0;

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("table read and write hit the same entry");

   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> ent_vld_ff[$past(wr_addr)])
      else $error("written entry not marked valid");

endmodule

FILE: src/periodic_task_release_scheduler.sv
// Periodic task release scheduler, top level.
// Depends on ptrs_pkg and ptrs_table.
//
// Usage:
//   Request channel (req_*): one item per transfer. kind selects tick, load or
//   suspend. A load writes one task entry and marks it running; a suspend
//   clears the running flag. Out-of-range task ids and unused kinds are dropped.
//   Response channel (rsp_*): a tick gives one transfer per released task in
//   index order (at most eight reported), then a closing transfer with
//   rsp_tick_done set and the missing-handler flag. Loads and suspends give none.
// Timing:
//   A load writes its entry directly; a suspend reads, then writes back the entry.
//   A tick sweeps the table through its single read and single write port, one
//   entry per cycle while no release is stalled at the output, overlapping the
//   read of one entry with the update of the previous.
//   req_ready is high only between operations.
// Stall: while the output register holds an untaken release, the sweep holds
//   on the entry that wants to release next; nothing is dropped.
// Reset: synchronous; every task entry reads as zero (not running) until loaded.
module periodic_task_release_scheduler
   import ptrs_pkg::*;
#(
   parameter int TASK_COUNT = TASK_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [TASK_ID_W-1:0] req_task_id,
   input  logic [TICK_W-1:0]    req_period_ticks,
   input  logic [TICK_W-1:0]    req_first_delay_ticks,
   input  logic                 req_has_handler,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_tick_done,
   output logic [TASK_ID_W-1:0] rsp_released_task,
   output logic                 rsp_missing_handler_error
);

   localparam int AW    = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int CNT_W = AW + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUSP,
      ST_SWEEP,
      ST_CLOSE
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [AW-1:0]          proc_idx_ff, proc_idx_in;
   logic                   proc_valid_ff, proc_valid_in;
   logic [REL_CNT_W-1:0]   rel_cnt_ff, rel_cnt_in;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_done_ff, rsp_done_in;
   logic [TASK_ID_W-1:0]   rsp_task_ff, rsp_task_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic                   rd_en, wr_en;
   logic [AW-1:0]          rd_addr, wr_addr, req_addr;
   task_entry_type         rd_entry, wr_entry, proc_next, load_entry;
   logic                   req_in_range, out_free, issue;
   logic                   hit, release_now, rel_emit, miss, stall;
   logic [TICK_W-1:0]      base_ticks;

   ptrs_table #(
      .TASK_COUNT (TASK_COUNT),
      .AW         (AW)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_addr     = AW'(req_task_id);
   assign req_in_range = (32'(req_task_id) < TASK_COUNT);
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign issue        = (rd_idx_ff < CNT_W'(TASK_COUNT));

   assign hit         = (rd_entry.remaining_ticks == '0) && rd_entry.running;
   assign release_now = hit && rd_entry.has_handler;
   assign miss        = hit && !rd_entry.has_handler;
   assign rel_emit    = release_now && (rel_cnt_ff < REL_CNT_W'(MAX_RELEASES));
   assign stall       = proc_valid_ff && rel_emit && !out_free;
   assign base_ticks  = release_now ? rd_entry.period_ticks : rd_entry.remaining_ticks;

   always_comb begin
      proc_next                 = rd_entry;
      proc_next.remaining_ticks = base_ticks - TICK_W'(1);
      load_entry.remaining_ticks = req_first_delay_ticks;
      load_entry.period_ticks    = req_period_ticks;
      load_entry.has_handler     = req_has_handler;
      load_entry.running         = 1'b1;
   end

   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      proc_idx_in   = proc_idx_ff;
      proc_valid_in = proc_valid_ff;
      rel_cnt_in    = rel_cnt_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_done_in   = rsp_done_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_err_in    = rsp_err_ff;
      rd_en         = 1'b0;
      rd_addr       = rd_idx_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = proc_idx_ff;
      wr_entry      = proc_next;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_LOAD: begin
                     if (req_in_range) begin
                        wr_en    = 1'b1;
                        wr_addr  = req_addr;
                        wr_entry = load_entry;
                     end
                  end
                  KIND_SUSPEND: begin
                     if (req_in_range) begin
                        rd_en       = 1'b1;
                        rd_addr     = req_addr;
                        proc_idx_in = req_addr;
                        state_in    = ST_SUSP;
                     end
                  end
                  KIND_TICK: begin
                     rd_idx_in     = '0;
                     rel_cnt_in    = '0;
                     err_in        = 1'b0;
                     proc_valid_in = 1'b0;
                     state_in      = ST_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SUSP: begin
            wr_en            = 1'b1;
            wr_entry         = rd_entry;
            wr_entry.running = 1'b0;
            state_in         = ST_IDLE;
         end
         ST_SWEEP: begin
            if (!stall) begin
               if (issue) begin
                  rd_en         = 1'b1;
                  proc_idx_in   = rd_idx_ff[AW-1:0];
                  rd_idx_in     = rd_idx_ff + CNT_W'(1);
                  proc_valid_in = 1'b1;
               end else begin
                  proc_valid_in = 1'b0;
               end
               if (proc_valid_ff) begin
                  wr_en = 1'b1;
                  if (rel_emit) begin
                     rsp_valid_in = 1'b1;
                     rsp_done_in  = 1'b0;
                     rsp_task_in  = TASK_ID_W'(proc_idx_ff);
                     rsp_err_in   = 1'b0;
                     rel_cnt_in   = rel_cnt_ff + REL_CNT_W'(1);
                  end
                  if (miss) begin
                     err_in = 1'b1;
                  end
               end
               if (!issue && !proc_valid_ff) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_CLOSE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_done_in  = 1'b1;
               rsp_task_in  = '0;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_idx_ff     <= '0;
         proc_valid_ff <= 1'b0;
         rel_cnt_ff    <= '0;
         err_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_idx_ff     <= rd_idx_in;
         proc_valid_ff <= proc_valid_in;
         rel_cnt_ff    <= rel_cnt_in;
         err_ff        <= err_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      proc_idx_ff <= proc_idx_in;
      rsp_done_ff <= rsp_done_in;
      rsp_task_ff <= rsp_task_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_tick_done             = rsp_done_ff;
   assign rsp_released_task         = rsp_task_ff;
   assign rsp_missing_handler_error = rsp_err_ff;

   a_release_cap: assert property (@(posedge clock) disable iff (reset)
      rel_cnt_ff <= REL_CNT_W'(MAX_RELEASES))
      else $error("release count above limit");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> (proc_valid_ff && $stable(proc_idx_ff) && $stable(rd_idx_ff)))
      else $error("sweep moved on during output stall");

   a_release_no_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_done_ff) |-> !rsp_err_ff)
      else $error("release transfer carries error flag");

   a_idle_no_work: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!proc_valid_ff && !stall))
      else $error("request accepted with sweep in flight");

endmodule

FILE: tb/sv/ptrs_release_checker.sv
`timescale 1ns / 1ps
// Release checker for the periodic task release scheduler: watches both channels,
// keeps its own copy of the task table and compares every response transfer.
// Depends on ptrs_pkg.
module ptrs_release_checker
   import ptrs_pkg::*;
#(
   parameter int TASK_COUNT = TASK_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [TASK_ID_W-1:0] req_task_id,
   input  logic [TICK_W-1:0]    req_period_ticks,
   input  logic [TICK_W-1:0]    req_first_delay_ticks,
   input  logic                 req_has_handler,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_tick_done,
   input  logic [TASK_ID_W-1:0] rsp_released_task,
   input  logic                 rsp_missing_handler_error,
   output int unsigned          mismatch_count,
   output int unsigned          owed_count
);

   typedef struct packed {
      logic                 tick_done;
      logic [TASK_ID_W-1:0] task_idx;
      logic                 no_handler;
   } release_note_type;

   logic [TICK_W-1:0] countdown    [TASK_COUNT];
   logic [TICK_W-1:0] reload_value [TASK_COUNT];
   logic              armed        [TASK_COUNT];
   logic              runnable     [TASK_COUNT];
   release_note_type  release_queue[$];
   int unsigned       misses;

   task automatic sweep_tick();
      int               reported;
      logic             missing;
      release_note_type note;
      reported = 0;
      missing  = 1'b0;
      for (int i = 0; i < TASK_COUNT; i++) begin
         if (countdown[i] == '0 && armed[i]) begin
            if (runnable[i]) begin
               if (reported < MAX_RELEASES) begin
                  note.tick_done  = 1'b0;
                  note.task_idx   = TASK_ID_W'(i);
                  note.no_handler = 1'b0;
                  release_queue.push_back(note);
                  reported++;
               end
               countdown[i] = reload_value[i];
            end else begin
               missing = 1'b1;
            end
         end
         countdown[i] = countdown[i] - 1'b1;
      end
      note.tick_done  = 1'b1;
      note.task_idx   = '0;
      note.no_handler = missing;
      release_queue.push_back(note);
   endtask

   task automatic apply_request();
      int idx;
      idx = int'(req_task_id);
      case (req_kind)
         KIND_TICK: begin
            sweep_tick();
         end
         KIND_LOAD: begin
            if (idx < TASK_COUNT) begin
               reload_value[idx] = req_period_ticks;
               countdown[idx]    = req_first_delay_ticks;
               runnable[idx]     = req_has_handler;
               armed[idx]        = 1'b1;
            end
         end
         KIND_SUSPEND: begin
            if (idx < TASK_COUNT) armed[idx] = 1'b0;
         end
         default: ;
      endcase
   endtask

   task automatic check_release();
      release_note_type want;
      if (release_queue.size() == 0) begin
         misses++;
         if (misses <= 10)
            $display("%0t: unexpected transfer: done=%0b task=%0d err=%0b", $realtime,
                     rsp_tick_done, rsp_released_task, rsp_missing_handler_error);
      end else begin
         want = release_queue.pop_front();
         if (want.tick_done != rsp_tick_done || want.task_idx != rsp_released_task
             || want.no_handler != rsp_missing_handler_error) begin
            misses++;
            if (misses <= 10)
               $display({"%0t: mismatch: expected done=%0b task=%0d err=%0b, ",
                         "got done=%0b task=%0d err=%0b"},
                        $realtime, want.tick_done, want.task_idx, want.no_handler,
                        rsp_tick_done, rsp_released_task, rsp_missing_handler_error);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_COUNT; i++) begin
            countdown[i]    = '0;
            reload_value[i] = '0;
            armed[i]        = 1'b0;
            runnable[i]     = 1'b0;
         end
         release_queue.delete();
         misses = 0;
      end else begin
         if (req_valid && req_ready) apply_request();
         if (rsp_valid && rsp_ready) check_release();
      end
      mismatch_count <= misses;
      owed_count     <= release_queue.size();
   end

endmodule

FILE: tb/sv/tb_periodic_task_release_scheduler.sv
`timescale 1ns / 1ps
// Testbench top for the periodic task release scheduler: drives directed and bursty
// random requests, stalls the response side and gives the verdict.
// Depends on ptrs_pkg, periodic_task_release_scheduler and ptrs_release_checker.
module tb_periodic_task_release_scheduler;
   import ptrs_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 96;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [KIND_W-1:0]    req_kind;
   logic [TASK_ID_W-1:0] req_task_id;
   logic [TICK_W-1:0]    req_period_ticks;
   logic [TICK_W-1:0]    req_first_delay_ticks;
   logic                 req_has_handler;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_tick_done;
   logic [TASK_ID_W-1:0] rsp_released_task;
   logic                 rsp_missing_handler_error;
   int unsigned          mismatch_count;
   int unsigned          owed_count;

   periodic_task_release_scheduler dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_kind                  (req_kind),
      .req_task_id               (req_task_id),
      .req_period_ticks          (req_period_ticks),
      .req_first_delay_ticks     (req_first_delay_ticks),
      .req_has_handler           (req_has_handler),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_tick_done             (rsp_tick_done),
      .rsp_released_task         (rsp_released_task),
      .rsp_missing_handler_error (rsp_missing_handler_error)
   );

   ptrs_release_checker checker_i (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_kind                  (req_kind),
      .req_task_id               (req_task_id),
      .req_period_ticks          (req_period_ticks),
      .req_first_delay_ticks     (req_first_delay_ticks),
      .req_has_handler           (req_has_handler),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_tick_done             (rsp_tick_done),
      .rsp_released_task         (rsp_released_task),
      .rsp_missing_handler_error (rsp_missing_handler_error),
      .mismatch_count            (mismatch_count),
      .owed_count                (owed_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("tb_periodic_task_release_scheduler: FAIL");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic offer(input logic [KIND_W-1:0] kind, input logic [TASK_ID_W-1:0] id,
                        input logic [TICK_W-1:0] period, input logic [TICK_W-1:0] delay,
                        input logic handler);
      req_valid             <= 1'b1;
      req_kind              <= kind;
      req_task_id           <= id;
      req_period_ticks      <= period;
      req_first_delay_ticks <= delay;
      req_has_handler       <= handler;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic offer_random(output bit counted);
      int                pick;
      logic [TICK_W-1:0] period;
      logic [TICK_W-1:0] delay;
      pick    = $urandom_range(0, 99);
      counted = 1'b1;
      delay   = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 6);
      case ($urandom_range(0, 9))
         0:       period = '0;
         1:       period = $urandom;
         default: period = $urandom_range(1, 5);
      endcase
      if (pick < 30) begin
         offer(KIND_TICK, TASK_ID_W'($urandom), $urandom, $urandom, 1'($urandom));
      end else if (pick < 75) begin
         offer(KIND_LOAD, TASK_ID_W'($urandom), period, delay, $urandom_range(0, 6) != 0);
      end else if (pick < 93) begin
         offer(KIND_SUSPEND, TASK_ID_W'($urandom), $urandom, $urandom, 1'($urandom));
      end else begin
         offer(KIND_UNUSED, TASK_ID_W'($urandom), $urandom, $urandom, 1'($urandom));
         counted = 1'b0;
      end
   endtask

   // response side: one long hold-off on the first response, then a mixed pattern
   initial begin
      int mode;
      int span;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset || !rsp_valid) @(negedge clock);
      repeat (100) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 11);
         span = (mode == 0) ? 80 : $urandom_range(4, 30);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0:             rsp_ready <= 1'b0;
               1, 2, 3, 4:    rsp_ready <= 1'b1;
               5, 6, 7, 8:    rsp_ready <= 1'($urandom_range(0, 1));
               default:       rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      int unsigned sent;
      int          burst;
      int          gap;
      bit          counted;
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_kind              = KIND_TICK;
      req_task_id           = '0;
      req_period_ticks      = '0;
      req_first_delay_ticks = '0;
      req_has_handler       = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, extremes, zero period, missing handler, suspend, unused kind
      offer(KIND_TICK, '0, '0, '0, 1'b0);
      offer(KIND_LOAD, 3'd0, '0, '0, 1'b1);
      offer(KIND_LOAD, 3'd7, '1, '1, 1'b1);
      offer(KIND_LOAD, 3'd3, 32'd2, '0, 1'b0);
      offer(KIND_LOAD, 3'd5, 32'd1, 32'd1, 1'b1);
      offer(KIND_LOAD, 3'd1, 32'd3, '0, 1'b1);
      offer(KIND_TICK, 3'd7, '1, '1, 1'b1);
      offer(KIND_TICK, '0, '0, '0, 1'b0);
      offer(KIND_SUSPEND, 3'd5, '1, '1, 1'b1);
      offer(KIND_SUSPEND, 3'd2, '0, '0, 1'b0);
      offer(KIND_UNUSED, 3'd6, $urandom, $urandom, 1'b1);
      offer(KIND_TICK, '0, '0, '0, 1'b0);
      // crowded tick: every entry due at once
      for (int i = 0; i < TASK_COUNT_DEF; i++)
         offer(KIND_LOAD, TASK_ID_W'(i), $urandom_range(1, 3), '0, 1'b1);
      offer(KIND_TICK, '0, '0, '0, 1'b0);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            offer_random(counted);
            if (counted) sent++;
         end
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b0;

      while (owed_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && owed_count == 0)
         $display("tb_periodic_task_release_scheduler: PASS");
      else
         $display("tb_periodic_task_release_scheduler: FAIL");
      $finish;
   end

endmodule

FILE: files.f
src/ptrs_pkg.sv
src/ptrs_table.sv
src/periodic_task_release_scheduler.sv
tb/sv/ptrs_release_checker.sv
tb/sv/tb_periodic_task_release_scheduler.sv
